@@ rtl/u8esc_pkg.sv @@
// ----------------------------------------------------------------------------
// u8esc_pkg
// Shared types, constants and the UTF-8 encode function of the whitespace
// escape encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package u8esc_pkg;

   // Action queue between the classifier and the byte emitter
   localparam int QueueDepth  = 4;
   localparam int QueuePtrW   = $clog2(QueueDepth);
   localparam int QueueCountW = $clog2(QueueDepth + 1);

   // Configuration port
   localparam int CsrAddrW = 5;
   localparam int CsrDataW = 32;

   // Register indexes, taken from paddr[4:2]
   localparam logic [2:0] REG_NEWLINE_MODE   = 3'd0;
   localparam logic [2:0] REG_ESCAPE_POINT   = 3'd1;
   localparam logic [2:0] REG_SPACE_POINT    = 3'd2;
   localparam logic [2:0] REG_TAB_POINT      = 3'd3;
   localparam logic [2:0] REG_LINEFEED_POINT = 3'd4;
   localparam logic [2:0] REG_RETURN_POINT   = 3'd5;

   localparam logic [20:0] ESCAPE_RESET   = 21'd9600;
   localparam logic [20:0] SPACE_RESET    = 21'd9601;
   localparam logic [20:0] TAB_RESET      = 21'd9602;
   localparam logic [20:0] LINEFEED_RESET = 21'd9603;
   localparam logic [20:0] RETURN_RESET   = 21'd9604;

   localparam logic [20:0] CP_SPACE    = 21'h20;
   localparam logic [20:0] CP_TAB      = 21'h09;
   localparam logic [20:0] CP_LINEFEED = 21'h0A;
   localparam logic [20:0] CP_RETURN   = 21'h0D;

   typedef logic [20:0]      point_type;
   typedef logic [3:0][7:0]  quad_type;

   typedef struct packed {
      logic      newline_mode;
      point_type escape_point;
      point_type space_point;
      point_type tab_point;
      point_type linefeed_point;
      point_type return_point;
   } cfg_type;

   // What the emitter has to do for one decoded unit
   typedef enum logic [1:0] {
      ACT_RAW    = 2'd0,   // pass the raw bytes
      ACT_POINT  = 2'd1,   // encode one code point
      ACT_ESCAPE = 2'd2    // encode the escape point, then the code point
   } act_kind_type;

   typedef struct packed {
      act_kind_type kind;
      point_type    point;
      quad_type     raw;
      logic [2:0]   raw_len;
      logic         fin;
   } act_type;

   typedef struct packed {
      quad_type   bytes;
      logic [2:0] len;
   } enc_type;

   // Shortest UTF-8 form of a 21-bit code point, first byte in bytes[0]
   function automatic enc_type utf8_encode(point_type cp);
      enc_type e;
      begin
         e = '0;
         if (cp <= 21'h7F) begin
            e.bytes[0] = cp[7:0];
            e.len      = 3'd1;
         end else if (cp <= 21'h7FF) begin
            e.bytes[0] = {3'b110, cp[10:6]};
            e.bytes[1] = {2'b10, cp[5:0]};
            e.len      = 3'd2;
         end else if (cp <= 21'hFFFF) begin
            e.bytes[0] = {4'b1110, cp[15:12]};
            e.bytes[1] = {2'b10, cp[11:6]};
            e.bytes[2] = {2'b10, cp[5:0]};
            e.len      = 3'd3;
         end else begin
            e.bytes[0] = {5'b11110, cp[20:18]};
            e.bytes[1] = {2'b10, cp[17:12]};
            e.bytes[2] = {2'b10, cp[11:6]};
            e.bytes[3] = {2'b10, cp[5:0]};
            e.len      = 3'd4;
         end
         return e;
      end
   endfunction

endpackage

`default_nettype wire

@@ rtl/u8esc_front.sv @@
// ----------------------------------------------------------------------------
// u8esc_front
// Accepts source bytes, holds a partial UTF-8 sequence and classifies one
// decoded unit per cycle into an emitter action while the queue has room.
// ----------------------------------------------------------------------------
`default_nettype none

module u8esc_front (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_tvalid,
   output logic                   req_tready,
   input  wire  [7:0]             req_tdata,
   input  wire                    req_tlast,
   input  u8esc_pkg::cfg_type     cfg,
   output logic                   q_push,
   output u8esc_pkg::act_type     q_data,
   input  wire                    q_full
);
   import u8esc_pkg::*;

   quad_type   pend_ff, pend_in;
   logic [2:0] pend_cnt_ff, pend_cnt_in;
   logic       busy_ff, busy_in;
   logic       last_ff, last_in;

   logic [2:0] need;
   logic       bad_cont, short_seq, bad, hold_wait;
   logic [2:0] drop, rem;
   point_type  cp;
   logic       emit, advance, finish, accept;
   quad_type   shifted, base_bytes;
   logic [2:0] base_cnt;

   always_comb begin
      // Sequence length from the lead byte; zero marks a bad lead
      if (!pend_ff[0][7])                  need = 3'd1;
      else if (pend_ff[0][7:5] == 3'b110)  need = 3'd2;
      else if (pend_ff[0][7:4] == 4'b1110) need = 3'd3;
      else if (pend_ff[0][7:3] == 5'b11110) need = 3'd4;
      else                                 need = 3'd0;

      bad_cont = 1'b0;
      for (int i = 1; i < 4; i++) begin
         if ((3'(i) < need) && (3'(i) < pend_cnt_ff) && (pend_ff[i][7:6] != 2'b10))
            bad_cont = 1'b1;
      end

      short_seq = pend_cnt_ff < need;
      bad       = (need == 3'd0) || bad_cont || (short_seq && last_ff);
      hold_wait = !bad && short_seq;
      drop      = bad ? 3'd1 : need;
      rem       = pend_cnt_ff - drop;

      case (need)
         3'd1:    cp = {13'd0, pend_ff[0]};
         3'd2:    cp = {10'd0, pend_ff[0][4:0], pend_ff[1][5:0]};
         3'd3:    cp = {5'd0, pend_ff[0][3:0], pend_ff[1][5:0], pend_ff[2][5:0]};
         default: cp = {pend_ff[0][2:0], pend_ff[1][5:0], pend_ff[2][5:0], pend_ff[3][5:0]};
      endcase

      q_data.raw     = pend_ff;
      q_data.raw_len = drop;
      q_data.fin     = last_ff && (rem == 3'd0);
      q_data.point   = cp;
      q_data.kind    = ACT_POINT;
      if (bad) begin
         q_data.kind = ACT_RAW;
      end else if (cp == CP_SPACE) begin
         q_data.point = cfg.space_point;
      end else if (cp == CP_TAB) begin
         q_data.point = cfg.tab_point;
      end else if (cfg.newline_mode && (cp == CP_LINEFEED)) begin
         q_data.point = cfg.linefeed_point;
      end else if (cfg.newline_mode && (cp == CP_RETURN)) begin
         q_data.point = cfg.return_point;
      end else if ((cp >= cfg.escape_point) && (cp <= cfg.return_point)) begin
         q_data.kind = ACT_ESCAPE;
      end else begin
         q_data.kind = ACT_RAW;
      end

      emit    = busy_ff && !hold_wait;
      q_push  = emit && !q_full;
      advance = busy_ff && (hold_wait || !q_full);
      finish  = hold_wait || (rem == 3'd0);

      // A new byte may join in the cycle that settles the buffer
      req_tready = !busy_ff || (advance && finish);
      accept     = req_tvalid && req_tready;

      shifted = pend_ff >> {drop, 3'b000};
      if (advance) begin
         base_bytes = hold_wait ? pend_ff : shifted;
         base_cnt   = hold_wait ? pend_cnt_ff : rem;
      end else begin
         base_bytes = pend_ff;
         base_cnt   = pend_cnt_ff;
      end

      pend_in     = base_bytes;
      pend_cnt_in = base_cnt;
      busy_in     = busy_ff;
      last_in     = last_ff;
      if (accept) begin
         pend_in[base_cnt[1:0]] = req_tdata;
         pend_cnt_in            = base_cnt + 3'd1;
         busy_in                = 1'b1;
         last_in                = req_tlast;
      end else if (advance) begin
         busy_in = !finish;
      end
   end

   always_ff @(posedge clock) begin
      pend_ff <= pend_in;
      if (reset) begin
         pend_cnt_ff <= 3'd0;
         busy_ff     <= 1'b0;
         last_ff     <= 1'b0;
      end else begin
         pend_cnt_ff <= pend_cnt_in;
         busy_ff     <= busy_in;
         last_ff     <= last_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/u8esc_queue.sv @@
// ----------------------------------------------------------------------------
// u8esc_queue
// Short first-in first-out queue of actions between classifier and emitter.
// ----------------------------------------------------------------------------
`default_nettype none

module u8esc_queue (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    push,
   input  u8esc_pkg::act_type     push_data,
   output logic                   full,
   input  wire                    pop,
   output u8esc_pkg::act_type     head,
   output logic                   empty
);
   import u8esc_pkg::*;

   act_type                entry_ff [QueueDepth];
   logic [QueuePtrW-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [QueueCountW-1:0] count_ff, count_in;
   logic                   do_push, do_pop;

   always_comb begin
      full     = count_ff == QueueCountW'(QueueDepth);
      empty    = count_ff == '0;
      head     = entry_ff[rd_ptr_ff];
      do_push  = push && !full;
      do_pop   = pop && !empty;
      count_in = count_ff + QueueCountW'(do_push) - QueueCountW'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (do_push) entry_ff[wr_ptr_ff] <= push_data;
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) wr_ptr_ff <= wr_ptr_ff + QueuePtrW'(1);
         if (do_pop)  rd_ptr_ff <= rd_ptr_ff + QueuePtrW'(1);
         count_ff <= count_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/u8esc_back.sv @@
// ----------------------------------------------------------------------------
// u8esc_back
// Expands queued actions into output bytes, one byte per cycle while the
// output is not stalled, through an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module u8esc_back (
   input  wire                    clock,
   input  wire                    reset,
   input  u8esc_pkg::point_type   escape_point,
   input  u8esc_pkg::act_type     q_head,
   input  wire                    q_empty,
   output logic                   q_pop,
   output logic                   rsp_tvalid,
   input  wire                    rsp_tready,
   output logic [7:0]             rsp_tdata,
   output logic                   rsp_tlast
);
   import u8esc_pkg::*;

   // Segment being sent, and the code point that follows an escape
   logic       seg_valid_ff, seg_valid_in;
   quad_type   seg_bytes_ff, seg_bytes_in;
   logic [2:0] seg_len_ff, seg_len_in;
   logic [1:0] seg_idx_ff, seg_idx_in;
   logic       seg_fin_ff, seg_fin_in;
   logic       second_valid_ff, second_valid_in;
   point_type  second_point_ff, second_point_in;
   logic       second_fin_ff, second_fin_in;

   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_data_ff, rsp_data_in;
   logic       rsp_last_ff, rsp_last_in;

   logic       out_free, emit, seg_done, need_load;
   enc_type    enc_second, enc_head;

   always_comb begin
      out_free  = !rsp_valid_ff || rsp_tready;
      emit      = seg_valid_ff && out_free;
      seg_done  = ({1'b0, seg_idx_ff} + 3'd1) == seg_len_ff;
      need_load = !seg_valid_ff || (emit && seg_done && !second_valid_ff);
      q_pop     = need_load && !q_empty;

      enc_second = utf8_encode(second_point_ff);
      enc_head   = utf8_encode(q_head.kind == ACT_ESCAPE ? escape_point : q_head.point);

      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = seg_bytes_ff[seg_idx_ff];
         rsp_last_in  = seg_fin_ff && seg_done;
      end else if (out_free) begin
         rsp_valid_in = 1'b0;
      end

      seg_valid_in    = seg_valid_ff;
      seg_bytes_in    = seg_bytes_ff;
      seg_len_in      = seg_len_ff;
      seg_idx_in      = seg_idx_ff;
      seg_fin_in      = seg_fin_ff;
      second_valid_in = second_valid_ff;
      second_point_in = second_point_ff;
      second_fin_in   = second_fin_ff;

      if (emit && !seg_done) begin
         seg_idx_in = seg_idx_ff + 2'd1;
      end else if (emit && seg_done && second_valid_ff) begin
         seg_bytes_in    = enc_second.bytes;
         seg_len_in      = enc_second.len;
         seg_idx_in      = 2'd0;
         seg_fin_in      = second_fin_ff;
         second_valid_in = 1'b0;
      end else if (need_load) begin
         seg_valid_in = q_pop;
         seg_idx_in   = 2'd0;
         seg_fin_in   = q_head.fin;
         case (q_head.kind)
            ACT_RAW: begin
               seg_bytes_in = q_head.raw;
               seg_len_in   = q_head.raw_len;
            end
            ACT_ESCAPE: begin
               seg_bytes_in    = enc_head.bytes;
               seg_len_in      = enc_head.len;
               seg_fin_in      = 1'b0;
               second_valid_in = q_pop;
               second_point_in = q_head.point;
               second_fin_in   = q_head.fin;
            end
            default: begin
               seg_bytes_in = enc_head.bytes;
               seg_len_in   = enc_head.len;
            end
         endcase
      end

      rsp_tvalid = rsp_valid_ff;
      rsp_tdata  = rsp_data_ff;
      rsp_tlast  = rsp_last_ff;
   end

   always_ff @(posedge clock) begin
      seg_bytes_ff    <= seg_bytes_in;
      seg_len_ff      <= seg_len_in;
      seg_idx_ff      <= seg_idx_in;
      seg_fin_ff      <= seg_fin_in;
      second_point_ff <= second_point_in;
      second_fin_ff   <= second_fin_in;
      rsp_data_ff     <= rsp_data_in;
      rsp_last_ff     <= rsp_last_in;
      if (reset) begin
         seg_valid_ff    <= 1'b0;
         second_valid_ff <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         seg_valid_ff    <= seg_valid_in;
         second_valid_ff <= second_valid_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/utf8_whitespace_escape_encoder_core.sv @@
// ----------------------------------------------------------------------------
// utf8_whitespace_escape_encoder_core
// Rewrites a UTF-8 byte stream, replacing spaces, tabs and, in newline mode,
// line feeds and returns with meta code points; meta-range points are escaped.
//
//   Channel   Direction  Handshake             Payload
//   req_*     in         tvalid/tready         tdata = in_byte, tlast = in_final
//   rsp_*     out        tvalid/tready         tdata = out_byte, tlast = out_final
//   csr_*     in         psel/penable/pready   six registers at 4*index
//
// An input item is taken every cycle while its bytes decode in one step and
// the action queue has room; an item ending an invalid sequence holds the
// input until the classifier has decoded each unit left in its buffer. The
// emitter sends one output byte per cycle unless stalled, so an item that
// expands to n bytes holds the output until all n are sent; a four-entry
// action queue lets the input run ahead. Reset is synchronous; no clearing.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_whitespace_escape_encoder_core (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              req_tvalid,
   output logic                             req_tready,
   input  wire  [7:0]                       req_tdata,   // [7:0] in_byte
   input  wire                              req_tlast,   // in_final
   output logic                             rsp_tvalid,
   input  wire                              rsp_tready,
   output logic [7:0]                       rsp_tdata,   // [7:0] out_byte
   output logic                             rsp_tlast,   // out_final
   input  wire                              csr_psel,
   input  wire                              csr_penable,
   input  wire                              csr_pwrite,
   input  wire  [u8esc_pkg::CsrAddrW-1:0]   csr_paddr,
   input  wire  [u8esc_pkg::CsrDataW-1:0]   csr_pwdata,
   output logic [u8esc_pkg::CsrDataW-1:0]   csr_prdata,
   output logic                             csr_pready
);
   import u8esc_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   logic [2:0] reg_index;
   logic       csr_write;

   act_type    q_in, q_head;
   logic       q_push, q_full, q_pop, q_empty;

   always_comb begin
      csr_pready = 1'b1;
      reg_index  = csr_paddr[CsrAddrW-1:2];
      csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

      cfg_in = cfg_ff;
      if (csr_write) begin
         case (reg_index)
            REG_NEWLINE_MODE:   cfg_in.newline_mode   = csr_pwdata[0];
            REG_ESCAPE_POINT:   cfg_in.escape_point   = csr_pwdata[20:0];
            REG_SPACE_POINT:    cfg_in.space_point    = csr_pwdata[20:0];
            REG_TAB_POINT:      cfg_in.tab_point      = csr_pwdata[20:0];
            REG_LINEFEED_POINT: cfg_in.linefeed_point = csr_pwdata[20:0];
            REG_RETURN_POINT:   cfg_in.return_point   = csr_pwdata[20:0];
            default:            cfg_in = cfg_ff;
         endcase
      end

      case (reg_index)
         REG_NEWLINE_MODE:   csr_prdata = {31'd0, cfg_ff.newline_mode};
         REG_ESCAPE_POINT:   csr_prdata = {11'd0, cfg_ff.escape_point};
         REG_SPACE_POINT:    csr_prdata = {11'd0, cfg_ff.space_point};
         REG_TAB_POINT:      csr_prdata = {11'd0, cfg_ff.tab_point};
         REG_LINEFEED_POINT: csr_prdata = {11'd0, cfg_ff.linefeed_point};
         REG_RETURN_POINT:   csr_prdata = {11'd0, cfg_ff.return_point};
         default:            csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.newline_mode   <= 1'b0;
         cfg_ff.escape_point   <= ESCAPE_RESET;
         cfg_ff.space_point    <= SPACE_RESET;
         cfg_ff.tab_point      <= TAB_RESET;
         cfg_ff.linefeed_point <= LINEFEED_RESET;
         cfg_ff.return_point   <= RETURN_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   u8esc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .cfg        (cfg_ff),
      .q_push     (q_push),
      .q_data     (q_in),
      .q_full     (q_full)
   );

   u8esc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in),
      .full      (q_full),
      .pop       (q_pop),
      .head      (q_head),
      .empty     (q_empty)
   );

   u8esc_back u_back (
      .clock        (clock),
      .reset        (reset),
      .escape_point (cfg_ff.escape_point),
      .q_head       (q_head),
      .q_empty      (q_empty),
      .q_pop        (q_pop),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tlast    (rsp_tlast)
   );

endmodule

`default_nettype wire

@@ rtl/u8esc_checker.sv @@
// ----------------------------------------------------------------------------
// u8esc_checker
// Port-level checks of the whitespace escape encoder, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module u8esc_checker (
   input wire                             clock,
   input wire                             reset,
   input wire                             req_tready,
   input wire                             rsp_tvalid,
   input wire                             rsp_tready,
   input wire [7:0]                       rsp_tdata,
   input wire                             rsp_tlast,
   input wire                             csr_psel,
   input wire                             csr_penable,
   input wire                             csr_pwrite,
   input wire [u8esc_pkg::CsrAddrW-1:0]   csr_paddr,
   input wire [u8esc_pkg::CsrDataW-1:0]   csr_pwdata,
   input wire [u8esc_pkg::CsrDataW-1:0]   csr_prdata
);
   import u8esc_pkg::*;

   // A stalled output item holds its value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("output item changed while stalled");

   // Reset leaves no output item behind.
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("output valid after reset");

   // Straight after reset the buffer is empty, so an item can be taken.
   assert property (@(posedge clock) reset |=> req_tready)
      else $error("input not ready after reset");

   // A written escape point reads back on the following cycle.
   assert property (@(posedge clock) disable iff (reset)
      csr_psel && csr_penable && csr_pwrite &&
      (csr_paddr[CsrAddrW-1:2] == REG_ESCAPE_POINT)
      |=> (csr_paddr != $past(csr_paddr)) ||
          (csr_prdata == {11'd0, $past(csr_pwdata[20:0])}))
      else $error("escape point read-back mismatch");

endmodule

bind utf8_whitespace_escape_encoder_core u8esc_checker u_checker (
   .clock       (clock),
   .reset       (reset),
   .req_tready  (req_tready),
   .rsp_tvalid  (rsp_tvalid),
   .rsp_tready  (rsp_tready),
   .rsp_tdata   (rsp_tdata),
   .rsp_tlast   (rsp_tlast),
   .csr_psel    (csr_psel),
   .csr_penable (csr_penable),
   .csr_pwrite  (csr_pwrite),
   .csr_paddr   (csr_paddr),
   .csr_pwdata  (csr_pwdata),
   .csr_prdata  (csr_prdata)
);

`default_nettype wire

@@ dv/escape_stream_checker.sv @@
// ----------------------------------------------------------------------------
// escape_stream_checker
// Follows the register port and both byte channels of the whitespace escape
// encoder, works out the output items that each accepted input item causes,
// and compares every accepted output item with the oldest one still awaited.
// ----------------------------------------------------------------------------
`default_nettype none

module escape_stream_checker (
   input  wire                             clock,
   input  wire                             reset,
   input  wire                             req_tvalid,
   input  wire                             req_tready,
   input  wire  [7:0]                      req_tdata,   // [7:0] in_byte
   input  wire                             req_tlast,   // in_final
   input  wire                             rsp_tvalid,
   input  wire                             rsp_tready,
   input  wire  [7:0]                      rsp_tdata,   // [7:0] out_byte
   input  wire                             rsp_tlast,   // out_final
   input  wire                             csr_psel,
   input  wire                             csr_penable,
   input  wire                             csr_pwrite,
   input  wire  [u8esc_pkg::CsrAddrW-1:0]  csr_paddr,
   input  wire  [u8esc_pkg::CsrDataW-1:0]  csr_pwdata,
   input  wire                             csr_pready,
   output int                              fail_count,
   output int                              outstanding
);

   import u8esc_pkg::*;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } out_item_type;

   // Register copies
   logic      nl_mode;
   point_type esc_cp;
   point_type spc_cp;
   point_type tab_cp;
   point_type lf_cp;
   point_type cr_cp;

   // Bytes waiting for the rest of their sequence
   logic [7:0] held [4];
   int         held_count;

   logic [7:0]   step_bytes [$];
   out_item_type expected_items [$];

   function automatic void put_byte(logic [7:0] b);
      if (step_bytes.size() < 8)
         step_bytes.push_back(b);
   endfunction

   function automatic void put_point(point_type cp);
      if (cp <= 21'h7F) begin
         put_byte(cp[7:0]);
      end else if (cp <= 21'h7FF) begin
         put_byte({3'b110, cp[10:6]});
         put_byte({2'b10, cp[5:0]});
      end else if (cp <= 21'hFFFF) begin
         put_byte({4'b1110, cp[15:12]});
         put_byte({2'b10, cp[11:6]});
         put_byte({2'b10, cp[5:0]});
      end else begin
         put_byte({5'b11110, cp[20:18]});
         put_byte({2'b10, cp[17:12]});
         put_byte({2'b10, cp[11:6]});
         put_byte({2'b10, cp[5:0]});
      end
   endfunction

   function automatic void drop_held(int k);
      int i;
      if (k > held_count)
         k = held_count;
      for (i = 0; i < 4 - k; i++)
         held[i] = held[i + k];
      held_count -= k;
   endfunction

   // Decodes as many whole units from the front of the held bytes as it can.
   // A unit that is structurally broken gives up its lead byte alone.
   function automatic void decode_held(logic fin);
      logic [7:0] lead;
      point_type  cp;
      int         need;
      int         avail;
      int         i;
      bit         bad;
      bit         wait_more;
      wait_more = 1'b0;
      while (held_count > 0 && !wait_more) begin
         lead = held[0];
         bad  = 1'b0;
         cp   = '0;
         if (lead < 8'h80)                need = 1;
         else if (lead[7:5] == 3'b110)    need = 2;
         else if (lead[7:4] == 4'b1110)   need = 3;
         else if (lead[7:3] == 5'b11110)  need = 4;
         else                             need = 0;
         if (need == 0) begin
            bad = 1'b1;
         end else begin
            avail = (held_count < need) ? held_count : need;
            for (i = 1; i < avail; i++)
               if (held[i][7:6] != 2'b10)
                  bad = 1'b1;
            if (!bad && held_count < need) begin
               if (fin)
                  bad = 1'b1;
               else
                  wait_more = 1'b1;
            end
         end
         if (wait_more) begin
            // The sequence may still be completed by later items.
         end else if (bad) begin
            put_byte(lead);
            drop_held(1);
         end else begin
            case (need)
               1: cp = {13'b0, lead};
               2: cp = {10'b0, lead[4:0], held[1][5:0]};
               3: cp = {5'b0, lead[3:0], held[1][5:0], held[2][5:0]};
               default: cp = {lead[2:0], held[1][5:0], held[2][5:0], held[3][5:0]};
            endcase
            if (cp == CP_SPACE) begin
               put_point(spc_cp);
            end else if (cp == CP_TAB) begin
               put_point(tab_cp);
            end else if (nl_mode && cp == CP_LINEFEED) begin
               put_point(lf_cp);
            end else if (nl_mode && cp == CP_RETURN) begin
               put_point(cr_cp);
            end else if (cp >= esc_cp && cp <= cr_cp) begin
               put_point(esc_cp);
               put_point(cp);
            end else begin
               for (i = 0; i < need; i++)
                  put_byte(held[i]);
            end
            drop_held(need);
         end
      end
   endfunction

   function automatic void predict_item(logic [7:0] b, logic fin);
      out_item_type item;
      int           i;
      if (held_count < 4) begin
         held[held_count] = b;
         held_count++;
      end
      step_bytes.delete();
      decode_held(fin);
      // The end of a stream empties the buffer whatever is left in it.
      if (fin)
         held_count = 0;
      for (i = 0; i < step_bytes.size(); i++) begin
         item.data = step_bytes[i];
         item.last = fin && (i == step_bytes.size() - 1);
         expected_items.push_back(item);
      end
   endfunction

   always @(posedge clock) begin : watch
      out_item_type want;
      if (reset) begin
         nl_mode    = 1'b0;
         esc_cp     = ESCAPE_RESET;
         spc_cp     = SPACE_RESET;
         tab_cp     = TAB_RESET;
         lf_cp      = LINEFEED_RESET;
         cr_cp      = RETURN_RESET;
         held_count = 0;
         fail_count = 0;
         expected_items.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[4:2])
               REG_NEWLINE_MODE:   nl_mode = csr_pwdata[0];
               REG_ESCAPE_POINT:   esc_cp  = csr_pwdata[20:0];
               REG_SPACE_POINT:    spc_cp  = csr_pwdata[20:0];
               REG_TAB_POINT:      tab_cp  = csr_pwdata[20:0];
               REG_LINEFEED_POINT: lf_cp   = csr_pwdata[20:0];
               REG_RETURN_POINT:   cr_cp   = csr_pwdata[20:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready)
            predict_item(req_tdata, req_tlast);
         if (rsp_tvalid && rsp_tready) begin
            if (expected_items.size() == 0) begin
               if (fail_count < 10)
                  $display("unexpected output item: byte %02h last %0b",
                           rsp_tdata, rsp_tlast);
               fail_count++;
            end else begin
               want = expected_items.pop_front();
               if (rsp_tdata !== want.data || rsp_tlast !== want.last) begin
                  if (fail_count < 10)
                     $display("output mismatch: expected byte %02h last %0b, got byte %02h last %0b",
                              want.data, want.last, rsp_tdata, rsp_tlast);
                  fail_count++;
               end
            end
         end
      end
      outstanding = expected_items.size();
   end

endmodule

`default_nettype wire

@@ dv/utf8_whitespace_escape_encoder_core_tb.sv @@
// ----------------------------------------------------------------------------
// utf8_whitespace_escape_encoder_core_tb
// Drives byte streams through the escape encoder under a series of register
// settings: a directed stream of edge cases first, then random streams of
// mostly well-formed UTF-8 with broken and truncated sequences mixed in.
// Channels pause at random outside calm phases; the checker predicts and compares.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_whitespace_escape_encoder_core_tb;

   import u8esc_pkg::*;

   localparam int StallLimit = 2000;
   localparam int Phases     = 8;
   localparam int RandomLen  = 26;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 req_tvalid;
   wire                  req_tready;
   logic [7:0]           req_tdata;    // [7:0] in_byte
   logic                 req_tlast;    // in_final
   wire                  rsp_tvalid;
   logic                 rsp_tready;
   wire  [7:0]           rsp_tdata;    // [7:0] out_byte
   wire                  rsp_tlast;    // out_final
   logic                 csr_psel;
   logic                 csr_penable;
   logic                 csr_pwrite;
   logic [CsrAddrW-1:0]  csr_paddr;
   logic [CsrDataW-1:0]  csr_pwdata;
   wire  [CsrDataW-1:0]  csr_prdata;
   wire                  csr_pready;

   int fail_count;
   int outstanding;
   int idle_cycles;
   bit calm;

   // Source text of the current phase, {in_final, in_byte} per item
   logic [8:0] text_q [$];
   point_type  meta_lo;
   point_type  meta_hi;

   logic [7:0] directed_bytes [25] = '{
      8'h20, 8'h09, 8'h0A, 8'h0D, 8'h00, 8'h7F,
      8'hF0, 8'h9F, 8'h98, 8'h80,
      8'hE2, 8'h96, 8'h80,
      8'h80, 8'hFF,
      8'hE2, 8'h41,
      8'hC0, 8'hA0,
      8'hF0, 8'h82, 8'h96, 8'h80,
      8'hE2, 8'h96
   };

   always #2 clock = ~clock;

   utf8_whitespace_escape_encoder_core u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   escape_stream_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_pready  (csr_pready),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   function automatic int draw_wait();
      if (calm || $urandom_range(0, 2) == 0)
         return 0;
      return $urandom_range(0, 11);
   endfunction

   function automatic point_type pick_point();
      point_type edges [8] = '{21'h0, 21'h7F, 21'h80, 21'h7FF,
                               21'h800, 21'hFFFF, 21'h10000, 21'h1FFFFF};
      case ($urandom_range(0, 3))
         0:       return edges[$urandom_range(0, 7)];
         1:       return 21'($urandom_range(0, 'h7F));
         2:       return 21'($urandom_range('h80, 'hFFFF));
         default: return 21'($urandom_range(0, 'h1FFFFF));
      endcase
   endfunction

   function automatic logic [7:0] lead_byte(int len);
      logic [7:0] r;
      r = 8'($urandom_range(0, 255));
      case (len)
         2:       return {3'b110, r[4:0]};
         3:       return {4'b1110, r[3:0]};
         default: return {5'b11110, r[2:0]};
      endcase
   endfunction

   function automatic logic [7:0] cont_byte();
      logic [7:0] r;
      r = 8'($urandom_range(0, 255));
      return {2'b10, r[5:0]};
   endfunction

   // Appends cp 'extra' bytes longer than its shortest form, at most four bytes.
   function automatic void add_point(point_type cp, int extra);
      int len;
      if (cp <= 21'h7F)         len = 1;
      else if (cp <= 21'h7FF)   len = 2;
      else if (cp <= 21'hFFFF)  len = 3;
      else                      len = 4;
      len += extra;
      if (len > 4)
         len = 4;
      case (len)
         1: text_q.push_back({2'b00, cp[6:0]});
         2: begin
            text_q.push_back({4'b0110, cp[10:6]});
            text_q.push_back({3'b010, cp[5:0]});
         end
         3: begin
            text_q.push_back({5'b01110, cp[15:12]});
            text_q.push_back({3'b010, cp[11:6]});
            text_q.push_back({3'b010, cp[5:0]});
         end
         default: begin
            text_q.push_back({6'b011110, cp[20:18]});
            text_q.push_back({3'b010, cp[17:12]});
            text_q.push_back({3'b010, cp[11:6]});
            text_q.push_back({3'b010, cp[5:0]});
         end
      endcase
   endfunction

   function automatic void add_unit();
      int          sel;
      int          len;
      int          i;
      int unsigned span;
      sel = $urandom_range(0, 99);
      len = $urandom_range(2, 4);
      if (sel < 20) begin
         case ($urandom_range(0, 3))
            0:       add_point(CP_SPACE, 0);
            1:       add_point(CP_TAB, 0);
            2:       add_point(CP_LINEFEED, 0);
            default: add_point(CP_RETURN, 0);
         endcase
      end else if (sel < 32) begin
         add_point(21'($urandom_range(0, 127)), 0);
      end else if (sel < 52 && meta_lo <= meta_hi) begin
         // Code points inside the escaped range, now and then in overlong form.
         span = 32'(meta_hi - meta_lo);
         if (span > 40)
            span = 40;
         add_point(21'(32'(meta_lo) + $urandom_range(0, span)),
                   ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0);
      end else if (sel < 72) begin
         case (len)
            2:       add_point(21'($urandom_range('h80, 'h7FF)), 0);
            3:       add_point(21'($urandom_range('h800, 'hFFFF)), 0);
            default: add_point(21'($urandom_range('h10000, 'h1FFFFF)), 0);
         endcase
      end else if (sel < 78) begin
         add_point(21'($urandom_range(0, 'h7FF)), $urandom_range(1, 2));
      end else if (sel < 86) begin
         text_q.push_back({1'b0, 8'($urandom_range(0, 255))});
      end else begin
         // A lead byte followed by too few continuation bytes; in the broken
         // variant a byte that cannot continue the sequence comes next.
         text_q.push_back({1'b0, lead_byte(len)});
         for (i = 0; i < $urandom_range(0, len - 2); i++)
            text_q.push_back({1'b0, cont_byte()});
         if (sel >= 93) begin
            if ($urandom_range(0, 1) == 0)
               text_q.push_back({2'b00, 7'($urandom_range(0, 127))});
            else
               text_q.push_back({1'b0, lead_byte($urandom_range(2, 4))});
         end
      end
      if ($urandom_range(0, 11) == 0)
         text_q[text_q.size() - 1][8] = 1'b1;
   endfunction

   task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready)
         @(posedge clock);
      @(negedge clock);
   endtask

   task automatic configure(input int phase);
      logic        nl;
      point_type   spc;
      point_type   tab;
      point_type   lf;
      int unsigned top_end;
      case (phase)
         0: begin
            nl = 1'b1;  meta_lo = ESCAPE_RESET;  meta_hi = RETURN_RESET;
            spc = SPACE_RESET;  tab = TAB_RESET;  lf = LINEFEED_RESET;
         end
         1: begin
            // Everything but spaces and tabs is escaped.
            nl = 1'b0;  meta_lo = 21'h0;  meta_hi = 21'h1FFFFF;
            spc = 21'h7F;  tab = 21'h80;  lf = 21'h10000;
         end
         2: begin
            // Inverted bounds leave the escaped range empty.
            nl = 1'b1;  meta_lo = 21'h1FFFFF;  meta_hi = 21'h0;
            spc = 21'h7FF;  tab = 21'h800;  lf = 21'hFFFF;
         end
         default: begin
            nl = 1'($urandom_range(0, 1));
            meta_lo = pick_point();
            top_end = 32'(meta_lo) + $urandom_range(0, 60);
            if ($urandom_range(0, 4) == 0)
               meta_hi = pick_point();
            else
               meta_hi = (top_end > 32'h1FFFFF) ? 21'h1FFFFF : top_end[20:0];
            spc = pick_point();
            tab = pick_point();
            lf  = pick_point();
         end
      endcase
      write_reg(REG_NEWLINE_MODE,   {31'b0, nl});
      write_reg(REG_ESCAPE_POINT,   {11'b0, meta_lo});
      write_reg(REG_SPACE_POINT,    {11'b0, spc});
      write_reg(REG_TAB_POINT,      {11'b0, tab});
      write_reg(REG_LINEFEED_POINT, {11'b0, lf});
      write_reg(REG_RETURN_POINT,   {11'b0, meta_hi});
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
   endtask

   // Valid is left high after an accepted item, so that a following item
   // with no gap goes out on the very next cycle.
   task automatic send_item(input logic [7:0] b, input logic fin);
      int gap;
      gap = draw_wait();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= fin;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_text();
      int i;
      for (i = 0; i < text_q.size(); i++)
         send_item(text_q[i][7:0], text_q[i][8]);
      req_tvalid <= 1'b0;
   endtask

   task automatic settle();
      while (outstanding != 0)
         @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   initial begin
      rsp_tready = 1'b0;
      @(negedge clock);
      forever begin
         int stall;
         stall = draw_wait();
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid)
            @(posedge clock);
         @(negedge clock);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_psel && csr_penable)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= StallLimit) begin
         $display("FAIL utf8_whitespace_escape_encoder_core");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int phase;
      int i;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = 8'h00;
      req_tlast   = 1'b0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      calm        = 1'b0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      for (phase = 0; phase < Phases; phase++) begin
         calm = (phase % 3 == 2);
         configure(phase);
         text_q.delete();
         if (phase == 0) begin
            for (i = 0; i < 25; i++)
               text_q.push_back({i == 24, directed_bytes[i]});
         end else begin
            while (text_q.size() < RandomLen)
               add_unit();
            text_q[text_q.size() - 1][8] = 1'b1;
         end
         send_text();
         settle();
      end
      repeat (12) @(negedge clock);
      if (fail_count == 0 && outstanding == 0)
         $display("PASS utf8_whitespace_escape_encoder_core");
      else
         $display("FAIL utf8_whitespace_escape_encoder_core");
      $finish;
   end

endmodule

`default_nettype wire

@@ filelist.f @@
rtl/u8esc_pkg.sv
rtl/u8esc_front.sv
rtl/u8esc_queue.sv
rtl/u8esc_back.sv
rtl/utf8_whitespace_escape_encoder_core.sv
rtl/u8esc_checker.sv
dv/escape_stream_checker.sv
dv/utf8_whitespace_escape_encoder_core_tb.sv
